[design/fpdt_pkg.sv]
// Shared types and constants for the decimal text formatter.
// No dependencies; imported by the front, queue, back and top modules.
package fpdt_pkg;

    localparam int NUM_DIGITS = 20;
    localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
    localparam int PLACES_W = 5;
    localparam int CHAR_W = 7;

    localparam logic [PLACES_W-1:0] MAX_PLACES = 5'd19;
    localparam logic [PLACES_W-1:0] PLACES_RESET = 5'd6;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_COMMA = 7'h2C;
    localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;

    typedef struct packed {
        logic [NUM_DIGITS-1:0][3:0] digits;
        logic [PLACES_W-1:0]        places;
        logic [DIGIT_IDX_W-1:0]     int_count;
    } fpdt_job_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_CONV,
        FR_PUSH
    } fr_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_INT,
        BK_COMMA,
        BK_POINT,
        BK_FRAC
    } bk_state_t;

endpackage

[design/fpdt_front.sv]
// Front end: accepts an amount, converts it to BCD one bit per cycle and
// counts its integer digits. Depends on fpdt_pkg.
module fpdt_front #(
    parameter int AMOUNT_WIDTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [63:0]                   amount,
    input  logic [fpdt_pkg::PLACES_W-1:0] decimal_places,
    output logic                          push_valid,
    input  logic                          push_ready,
    output fpdt_pkg::fpdt_job_t           push_job
);
    import fpdt_pkg::*;

    localparam int CNT_W = (AMOUNT_WIDTH > 1) ? $clog2(AMOUNT_WIDTH) : 1;

    fr_state_t                  state_reg, state_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [AMOUNT_WIDTH-1:0]    bin_reg, bin_next;
    logic [NUM_DIGITS-1:0][3:0] bcd_reg, bcd_next;
    logic [PLACES_W-1:0]        places_reg, places_next;

    logic [NUM_DIGITS-1:0][3:0] bcd_adj;
    logic [DIGIT_IDX_W-1:0]     top_idx;
    logic                       any_nz;
    logic [DIGIT_IDX_W-1:0]     int_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        bin_reg    <= bin_next;
        bcd_reg    <= bcd_next;
        places_reg <= places_next;
    end

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    always_comb
    begin
        top_idx = '0;
        any_nz  = 1'b0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i] != 4'd0)
            begin
                top_idx = DIGIT_IDX_W'(i);
                any_nz  = 1'b1;
            end
        end
        if (!any_nz || (top_idx < places_reg))
        begin
            int_count = DIGIT_IDX_W'(1);
        end
        else
        begin
            int_count = top_idx - places_reg + DIGIT_IDX_W'(1);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        bin_next    = bin_reg;
        bcd_next    = bcd_reg;
        places_next = places_reg;
        in_ready    = 1'b0;
        push_valid  = 1'b0;
        case (state_reg)
            FR_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    bin_next    = amount[AMOUNT_WIDTH-1:0];
                    bcd_next    = '0;
                    cnt_next    = CNT_W'(AMOUNT_WIDTH - 1);
                    places_next = (decimal_places > MAX_PLACES) ? MAX_PLACES
                                                                : decimal_places;
                    state_next  = FR_CONV;
                end
            end
            FR_CONV:
            begin
                bcd_next = {bcd_adj[NUM_DIGITS-1:0]} << 1;
                bcd_next[0][0] = bin_reg[AMOUNT_WIDTH-1];
                bin_next = bin_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = FR_PUSH;
                end
            end
            FR_PUSH:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    assign push_job.digits    = bcd_reg;
    assign push_job.places    = places_reg;
    assign push_job.int_count = int_count;

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == FR_IDLE))
        else $error("front ready outside idle");
    a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !push_ready) |=> (push_valid && $stable(push_job)))
        else $error("front job changed while stalled");
    a_conv_ends_in_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FR_CONV && cnt_reg == '0) |=> (state_reg == FR_PUSH))
        else $error("conversion did not hand off");

endmodule

[design/fpdt_queue.sv]
// Two-entry job queue between the front and back ends.
// Depends on fpdt_pkg for the job type.
module fpdt_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  fpdt_pkg::fpdt_job_t push_job,
    output logic                pop_valid,
    input  logic                pop,
    output fpdt_pkg::fpdt_job_t pop_job
);
    import fpdt_pkg::*;

    fpdt_job_t  mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count out of range");
    a_ptrs_match_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("pop from empty queue");

endmodule

[design/fpdt_back.sv]
// Back end: walks one queued job and emits its characters, one per cycle while
// out_ready accepts them, through an output register. Depends on fpdt_pkg.
module fpdt_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              job_valid,
    input  fpdt_pkg::fpdt_job_t               job,
    output logic                              job_pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [fpdt_pkg::CHAR_W-1:0]       text_char,
    output logic                              last_char
);
    import fpdt_pkg::*;

    function automatic logic [1:0] mod3_5(input logic [4:0] x);
        logic [2:0] s;
        s = 3'(x[0]) + 3'(x[2]) + 3'(x[4]) + {1'b0, x[1], 1'b0} + {1'b0, x[3], 1'b0};
        if (s >= 3'd6)
        begin
            s = s - 3'd6;
        end
        else if (s >= 3'd3)
        begin
            s = s - 3'd3;
        end
        return s[1:0];
    endfunction

    bk_state_t              state_reg, state_next;
    logic [DIGIT_IDX_W-1:0] idx_reg, idx_next;
    logic [DIGIT_IDX_W-1:0] rem_reg, rem_next;
    logic [1:0]             m3_reg, m3_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;

    logic                   load;
    logic [CHAR_W-1:0]      digit_char;
    logic [DIGIT_IDX_W-1:0] first_rem;

    assign load       = !out_valid_reg || out_ready;
    assign digit_char = CH_ZERO + CHAR_W'(job.digits[idx_reg]);
    assign first_rem  = job.int_count - DIGIT_IDX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        rem_reg  <= rem_next;
        m3_reg   <= m3_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        rem_next       = rem_reg;
        m3_next        = m3_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        job_pop        = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    idx_next   = job.places + first_rem;
                    rem_next   = first_rem;
                    m3_next    = mod3_5(first_rem);
                    state_next = BK_INT;
                end
            end
            BK_INT:
            begin
                if (load)
                begin
                    char_next      = digit_char;
                    out_valid_next = 1'b1;
                    last_next      = 1'b0;
                    if (rem_reg == '0)
                    begin
                        if (job.places != '0)
                        begin
                            state_next = BK_POINT;
                        end
                        else
                        begin
                            last_next  = 1'b1;
                            job_pop    = 1'b1;
                            state_next = BK_IDLE;
                        end
                    end
                    else
                    begin
                        rem_next = rem_reg - DIGIT_IDX_W'(1);
                        idx_next = idx_reg - DIGIT_IDX_W'(1);
                        if (m3_reg == 2'd0)
                        begin
                            m3_next    = 2'd2;
                            state_next = BK_COMMA;
                        end
                        else
                        begin
                            m3_next = m3_reg - 2'd1;
                        end
                    end
                end
            end
            BK_COMMA:
            begin
                if (load)
                begin
                    char_next      = CH_COMMA;
                    out_valid_next = 1'b1;
                    last_next      = 1'b0;
                    state_next     = BK_INT;
                end
            end
            BK_POINT:
            begin
                if (load)
                begin
                    char_next      = CH_POINT;
                    out_valid_next = 1'b1;
                    last_next      = 1'b0;
                    idx_next       = job.places - DIGIT_IDX_W'(1);
                    state_next     = BK_FRAC;
                end
            end
            BK_FRAC:
            begin
                if (load)
                begin
                    char_next      = digit_char;
                    out_valid_next = 1'b1;
                    last_next      = (idx_reg == '0);
                    idx_next       = idx_reg - DIGIT_IDX_W'(1);
                    if (idx_reg == '0)
                    begin
                        job_pop    = 1'b1;
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign text_char = char_reg;
    assign last_char = last_reg;

    a_point_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && text_char == CH_POINT) |-> !last_char)
        else $error("point flagged as last character");
    a_pop_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> (out_valid && last_char))
        else $error("job retired without a last character");
    a_work_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BK_IDLE) |-> job_valid)
        else $error("back end running without a queued job");

endmodule

[design/fixed_point_decimal_text_formatter.sv]
// Top level of the decimal text formatter: places register, front end,
// job queue and back end. Depends on fpdt_pkg, fpdt_front, fpdt_queue, fpdt_back.
//
// Takes one unsigned amount per word and emits its decimal text one ASCII
// character per word, most significant first: integer digits with a comma
// before every third digit left of the point, then '.' and decimal_places
// fractional digits when places is nonzero (values above 19 act as 19).
// last_char marks the final character. The front end converts the amount to
// BCD one bit per cycle, and the back end emits one character per cycle
// while out_ready accepts them, after a setup step in its idle state. A
// two-entry queue lets both run at once, so the front end can accept a new
// amount while the back end is still emitting the last one, unless the
// output side stalls and the queue fills. Writes to decimal_places take
// effect for amounts accepted afterwards.
module fixed_point_decimal_text_formatter #(
    parameter int AMOUNT_WIDTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [fpdt_pkg::PLACES_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [63:0]                   amount,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fpdt_pkg::CHAR_W-1:0]   text_char,
    output logic                          last_char
);
    import fpdt_pkg::*;

    logic [PLACES_W-1:0] places_reg, places_next;
    logic                push_valid, push_ready;
    fpdt_job_t           push_job;
    logic                job_valid, job_pop;
    fpdt_job_t           job;

    assign places_next = cfg_write ? cfg_data : places_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            places_reg <= PLACES_RESET;
        end
        else
        begin
            places_reg <= places_next;
        end
    end

    fpdt_front #(
        .AMOUNT_WIDTH (AMOUNT_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .amount         (amount),
        .decimal_places (places_reg),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_job       (push_job)
    );

    fpdt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (job_valid),
        .pop        (job_pop),
        .pop_job    (job)
    );

    fpdt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .text_char (text_char),
        .last_char (last_char)
    );

endmodule
